>>> rtl/adi_pkg.sv
// ----------------------------------------------------------------------------
// adi_pkg
// Shared widths, reset values, codes and control types of the accelerometer
// double integrator.
// ----------------------------------------------------------------------------
package adi_pkg;

  // Number of computed axes; result fields of higher axes read as zero.
  localparam int AXES       = 3;
  localparam int AXIS_PORTS = 3;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int OFFSET_W   = 16;
  localparam int SCALE_W    = 16;
  localparam int STEP_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int FLOOR_W    = 31;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_ADDR_W = 3;
  localparam int VEL_W      = 32;
  localparam int DIST_W     = 48;

  // Intermediate widths of one axis.
  localparam int FRAC       = 16;         // fractional bits of the Q formats
  localparam int DIFF_W     = 17;         // sample minus offset
  localparam int ACC_W      = 24;         // Q8.16 acceleration
  localparam int P1_W       = 40;         // acceleration times step time
  localparam int R1_W       = 25;         // rounded velocity increment
  localparam int Q_W        = 40;         // rounded second-order distance term

  // Bit-serial multiplier sizes.
  localparam int MC_W       = 40;
  localparam int MR_W       = 17;
  localparam int HI_W       = 42;
  localparam int PROD_W     = HI_W + MR_W;
  localparam int CNT_W      = $clog2(MR_W);

  // Register reset values.
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd2571;
  localparam logic [STEP_W-1:0]  STEP_RST  = 16'd3277;
  localparam logic [BLEND_W-1:0] BLEND_RST = 17'd52429;
  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd655;

  // Accumulator preloads that fold rounding constants into the products.
  localparam logic [HI_W-1:0] PRE_HALF16 = HI_W'(64'h0000_0000_8000);
  localparam logic [HI_W-1:0] PRE_DIST2  = HI_W'(64'h0001_0001_0000);

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_OFFSET_X     = 3'd0,
    CFG_OFFSET_Y     = 3'd1,
    CFG_OFFSET_Z     = 3'd2,
    CFG_COUNT_SCALE  = 3'd3,
    CFG_STEP_TIME    = 3'd4,
    CFG_BLEND_WEIGHT = 3'd5,
    CFG_SPEED_FLOOR  = 3'd6
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POST,
    ST_WRITE
  } state_t;

  // Products formed per axis, in order.
  typedef enum logic [2:0] {
    OP_SCALE,     // (sample - offset) * count_scale
    OP_VEL,       // acceleration * step_time
    OP_BLEND,     // velocity increment * blend_weight
    OP_DIST2,     // (acceleration * step_time) * step_time
    OP_DIST1      // prior velocity * step_time
  } op_t;

  // Strobes from the sequencer to the axis lanes.
  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic post;
    logic commit;
    op_t  op;
  } lane_ctl_t;

endpackage

>>> rtl/adi_sermul.sv
// ----------------------------------------------------------------------------
// adi_sermul
// Bit-serial multiplier: signed multiplicand times unsigned multiplier, one
// multiplier bit per cycle while step is high, with an addend preloaded into the accumulator.
// ----------------------------------------------------------------------------
module adi_sermul (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               step,
  input  logic signed [adi_pkg::MC_W-1:0]    mcand,
  input  logic        [adi_pkg::MR_W-1:0]    mplier,
  input  logic        [adi_pkg::HI_W-1:0]    preload,
  output logic signed [adi_pkg::PROD_W-1:0]  prod
);

  logic signed [adi_pkg::MC_W-1:0] mc_r;
  logic        [adi_pkg::MR_W-1:0] mr_r;
  logic        [adi_pkg::MR_W-1:0] mr_nxt;
  logic signed [adi_pkg::HI_W-1:0] hi_r;
  logic signed [adi_pkg::HI_W-1:0] hi_nxt;
  logic        [adi_pkg::MR_W-1:0] lo_r;
  logic        [adi_pkg::MR_W-1:0] lo_nxt;
  logic signed [adi_pkg::HI_W:0]   addend;
  logic signed [adi_pkg::HI_W:0]   sum;

  // Add the multiplicand when the current multiplier bit is set, then shift
  // the partial product one place into the low word.
  always_comb begin
    addend = mr_r[0] ? (adi_pkg::HI_W + 1)'(mc_r) : '0;
    sum    = (adi_pkg::HI_W + 1)'(hi_r) + addend;
    hi_nxt = sum[adi_pkg::HI_W:1];
    lo_nxt = {sum[0], lo_r[adi_pkg::MR_W-1:1]};
    mr_nxt = mr_r >> 1;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mc_r <= mcand;
      mr_r <= mplier;
      hi_r <= preload;
      lo_r <= '0;
    end else if (step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      mr_r <= mr_nxt;
    end
  end

  assign prod = {hi_r, lo_r};

endmodule

>>> rtl/adi_lane.sv
// ----------------------------------------------------------------------------
// adi_lane
// Datapath of one axis: offset removal, scaling, velocity integration with
// blend and dead zone, distance update, and the axis result register.
// ----------------------------------------------------------------------------
module adi_lane (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  adi_pkg::lane_ctl_t                    ctl,
  input  logic signed [adi_pkg::SAMPLE_W-1:0]   sample,
  input  logic signed [adi_pkg::OFFSET_W-1:0]   offset,
  input  logic        [adi_pkg::SCALE_W-1:0]    count_scale,
  input  logic        [adi_pkg::STEP_W-1:0]     step_time,
  input  logic        [adi_pkg::BLEND_W-1:0]    blend_weight,
  input  logic        [adi_pkg::FLOOR_W-1:0]    speed_floor,
  output logic signed [adi_pkg::DIST_W-1:0]     distance,
  output logic signed [adi_pkg::VEL_W-1:0]      vel
);

  localparam int ACC_HI = adi_pkg::ACC_W - 1;

  // Working registers of the current sample.
  logic signed [adi_pkg::DIFF_W-1:0] diff_r;
  logic signed [adi_pkg::ACC_W-1:0]  acc_r;
  logic signed [adi_pkg::P1_W-1:0]   p1_r;
  logic signed [adi_pkg::R1_W-1:0]   r1_r;
  logic signed [adi_pkg::VEL_W-1:0]  vf_r;
  logic signed [adi_pkg::Q_W-1:0]    q_r;

  // Axis state and result register.
  logic signed [adi_pkg::VEL_W-1:0]  pv_r;
  logic signed [adi_pkg::DIST_W-1:0] pd_r;
  logic signed [adi_pkg::VEL_W-1:0]  out_vel_r;
  logic signed [adi_pkg::DIST_W-1:0] out_dist_r;

  // Multiplier operands and product.
  logic signed [adi_pkg::MC_W-1:0]   mcand;
  logic        [adi_pkg::MR_W-1:0]   mplier;
  logic        [adi_pkg::HI_W-1:0]   preload;
  logic signed [adi_pkg::PROD_W-1:0] prod;

  // Post-processing values.
  logic        [adi_pkg::PROD_W-ACC_HI-1:0] acc_top;
  logic signed [adi_pkg::ACC_W-1:0]  acc_sat;
  logic        [adi_pkg::P1_W:0]     r1_sum;
  logic signed [adi_pkg::R1_W-1:0]   blend_inc;
  logic signed [adi_pkg::VEL_W:0]    vel_sum;
  logic signed [adi_pkg::VEL_W-1:0]  vel_sat;
  logic        [adi_pkg::VEL_W-1:0]  vel_neg;
  logic        [adi_pkg::VEL_W-1:0]  vel_mag;
  logic signed [adi_pkg::VEL_W-1:0]  vel_zone;
  logic signed [adi_pkg::DIST_W-adi_pkg::FRAC:0] dist_inc;
  logic signed [adi_pkg::DIST_W:0]   dist_sum;
  logic signed [adi_pkg::DIST_W-1:0] dist_sat;

  // Operand selection for the product about to start.
  always_comb begin
    unique case (ctl.op)
      adi_pkg::OP_SCALE: begin
        mcand   = adi_pkg::MC_W'(diff_r);
        mplier  = adi_pkg::MR_W'(count_scale);
        preload = '0;
      end
      adi_pkg::OP_VEL: begin
        mcand   = adi_pkg::MC_W'(acc_r);
        mplier  = adi_pkg::MR_W'(step_time);
        preload = '0;
      end
      adi_pkg::OP_BLEND: begin
        mcand   = adi_pkg::MC_W'(r1_r);
        mplier  = blend_weight;
        preload = adi_pkg::PRE_HALF16;
      end
      adi_pkg::OP_DIST2: begin
        mcand   = p1_r;
        mplier  = adi_pkg::MR_W'(step_time);
        preload = adi_pkg::PRE_DIST2;
      end
      adi_pkg::OP_DIST1: begin
        mcand   = adi_pkg::MC_W'(pv_r);
        mplier  = adi_pkg::MR_W'(step_time);
        preload = adi_pkg::HI_W'(q_r);
      end
      default: begin
        mcand   = '0;
        mplier  = '0;
        preload = '0;
      end
    endcase
  end

  adi_sermul u_sermul (
    .clk     (clk),
    .load    (ctl.load),
    .step    (ctl.step),
    .mcand   (mcand),
    .mplier  (mplier),
    .preload (preload),
    .prod    (prod)
  );

  // Acceleration saturates to Q8.16 when the bits above it disagree.
  always_comb begin
    acc_top = prod[adi_pkg::PROD_W-1:ACC_HI];
    if ((&acc_top) || !(|acc_top)) begin
      acc_sat = prod[adi_pkg::ACC_W-1:0];
    end else if (prod[adi_pkg::PROD_W-1]) begin
      acc_sat = {1'b1, {(adi_pkg::ACC_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(adi_pkg::ACC_W-1){1'b1}}};
    end
  end

  // Velocity increment rounded half up to Q9.16.
  assign r1_sum = prod[adi_pkg::P1_W:0] + (adi_pkg::P1_W + 1)'(adi_pkg::PRE_HALF16);

  // Blended velocity: prior velocity plus the weighted, rounded increment.
  always_comb begin
    blend_inc = prod[adi_pkg::R1_W+adi_pkg::FRAC-1:adi_pkg::FRAC];
    vel_sum   = (adi_pkg::VEL_W + 1)'(pv_r) + (adi_pkg::VEL_W + 1)'(blend_inc);
    if (vel_sum[adi_pkg::VEL_W] == vel_sum[adi_pkg::VEL_W-1]) begin
      vel_sat = vel_sum[adi_pkg::VEL_W-1:0];
    end else if (vel_sum[adi_pkg::VEL_W]) begin
      vel_sat = {1'b1, {(adi_pkg::VEL_W-1){1'b0}}};
    end else begin
      vel_sat = {1'b0, {(adi_pkg::VEL_W-1){1'b1}}};
    end
  end

  // Dead zone: magnitudes below the floor become zero.
  always_comb begin
    vel_neg  = '0 - vf_r;
    vel_mag  = vf_r[adi_pkg::VEL_W-1] ? vel_neg : vf_r;
    vel_zone = (vel_mag < adi_pkg::VEL_W'(speed_floor)) ? '0 : vf_r;
  end

  // New distance: prior distance plus the rounded increment, saturated.
  always_comb begin
    dist_inc = prod[adi_pkg::DIST_W:adi_pkg::FRAC];
    dist_sum = (adi_pkg::DIST_W + 1)'(pd_r) + (adi_pkg::DIST_W + 1)'(dist_inc);
    if (dist_sum[adi_pkg::DIST_W] == dist_sum[adi_pkg::DIST_W-1]) begin
      dist_sat = dist_sum[adi_pkg::DIST_W-1:0];
    end else if (dist_sum[adi_pkg::DIST_W]) begin
      dist_sat = {1'b1, {(adi_pkg::DIST_W-1){1'b0}}};
    end else begin
      dist_sat = {1'b0, {(adi_pkg::DIST_W-1){1'b1}}};
    end
  end

  // Working registers, written as each product finishes.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      diff_r <= adi_pkg::DIFF_W'(sample) - adi_pkg::DIFF_W'(offset);
    end
    if (ctl.post) begin
      case (ctl.op)
        adi_pkg::OP_SCALE: begin
          acc_r <= acc_sat;
        end
        adi_pkg::OP_VEL: begin
          p1_r <= prod[adi_pkg::P1_W-1:0];
          r1_r <= r1_sum[adi_pkg::P1_W:adi_pkg::FRAC];
        end
        adi_pkg::OP_BLEND: begin
          vf_r <= vel_sat;
        end
        adi_pkg::OP_DIST2: begin
          q_r  <= prod[adi_pkg::Q_W+adi_pkg::FRAC:adi_pkg::FRAC+1];
          vf_r <= vel_zone;
        end
        default: begin
        end
      endcase
    end
  end

  // Velocity and distance state, updated once the last product is done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      pd_r <= '0;
    end else if (ctl.post && (ctl.op == adi_pkg::OP_DIST1)) begin
      pv_r <= vf_r;
      pd_r <= dist_sat;
    end
  end

  // Result register, loaded when the output slot is free.
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_vel_r  <= pv_r;
      out_dist_r <= pd_r;
    end
  end

  assign vel      = out_vel_r;
  assign distance = out_dist_r;

endmodule

>>> rtl/adi_ctrl.sv
// ----------------------------------------------------------------------------
// adi_ctrl
// Sequencer shared by the axis lanes: input handshake, the five serial
// products per sample, and the output valid register.
// ----------------------------------------------------------------------------
module adi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output adi_pkg::lane_ctl_t ctl
);

  localparam logic [adi_pkg::CNT_W-1:0] LAST_BIT = adi_pkg::CNT_W'(adi_pkg::MR_W - 1);

  adi_pkg::state_t                state_r;
  adi_pkg::state_t                state_nxt;
  adi_pkg::op_t                   op_r;
  adi_pkg::op_t                   op_nxt;
  adi_pkg::op_t                   op_succ;
  logic [adi_pkg::CNT_W-1:0]      cnt_r;
  logic [adi_pkg::CNT_W-1:0]      cnt_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           slot_free;

  // The result register can take a new request when empty or being drained.
  assign slot_free = !out_valid_r || !out_stall;

  // Order of the products within one sample.
  always_comb begin
    unique case (op_r)
      adi_pkg::OP_SCALE: op_succ = adi_pkg::OP_VEL;
      adi_pkg::OP_VEL:   op_succ = adi_pkg::OP_BLEND;
      adi_pkg::OP_BLEND: op_succ = adi_pkg::OP_DIST2;
      adi_pkg::OP_DIST2: op_succ = adi_pkg::OP_DIST1;
      default:           op_succ = adi_pkg::OP_SCALE;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      adi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = adi_pkg::ST_LOAD;
        end
      end
      adi_pkg::ST_LOAD: begin
        state_nxt = adi_pkg::ST_MUL;
      end
      adi_pkg::ST_MUL: begin
        if (cnt_r == LAST_BIT) begin
          state_nxt = adi_pkg::ST_POST;
        end
      end
      adi_pkg::ST_POST: begin
        if (op_r == adi_pkg::OP_DIST1) begin
          state_nxt = adi_pkg::ST_WRITE;
        end else begin
          state_nxt = adi_pkg::ST_LOAD;
        end
      end
      adi_pkg::ST_WRITE: begin
        if (slot_free) begin
          state_nxt = adi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = adi_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall    = 1'b1;
    ctl.capture = 1'b0;
    ctl.load    = 1'b0;
    ctl.step    = 1'b0;
    ctl.post    = 1'b0;
    ctl.commit  = 1'b0;
    ctl.op      = op_r;
    unique case (state_r)
      adi_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      adi_pkg::ST_LOAD: begin
        ctl.load = 1'b1;
      end
      adi_pkg::ST_MUL: begin
        ctl.step = 1'b1;
      end
      adi_pkg::ST_POST: begin
        ctl.post = 1'b1;
      end
      adi_pkg::ST_WRITE: begin
        ctl.commit = slot_free;
      end
      default: begin
      end
    endcase
  end

  // Product index and bit counter.
  always_comb begin
    op_nxt  = op_r;
    cnt_nxt = cnt_r;
    if (ctl.capture) begin
      op_nxt = adi_pkg::OP_SCALE;
    end else if (ctl.post) begin
      op_nxt = op_succ;
    end
    if (ctl.load) begin
      cnt_nxt = '0;
    end else if (ctl.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  // Output valid: set by a new result, cleared when the request is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= adi_pkg::ST_IDLE;
      op_r        <= adi_pkg::OP_SCALE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/accel_double_integrator_top.sv
// ----------------------------------------------------------------------------
// accel_double_integrator_top
// Dead reckoning from a three-axis accelerometer: per axis, offset removal,
// scaling, blended velocity with dead zone, and saturating distance.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_stall   in_sample_x, in_sample_y, in_sample_z
//   out      out_valid / out_stall out_dist_x/y/z, out_vel_x/y/z
//   cfg      cfg_we                cfg_addr, cfg_wdata
//
// From acceptance to a valid result, each axis lane forms five products in
// sequence on one bit-serial multiplier, each product taking a load step,
// one shift-add step per multiplier bit and a post step; then the result
// register loads. The axes run in parallel. A new sample is accepted the
// cycle after the result loads, so the block takes no new sample while one
// is still being computed.
// Synchronous rst_n restores register defaults and clears velocity and
// distance. While out_stall holds a result, one further sample is accepted
// and computed, then waits until the result register frees up.
// ----------------------------------------------------------------------------
module accel_double_integrator_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [adi_pkg::SAMPLE_W-1:0]   in_sample_x,
  input  logic signed [adi_pkg::SAMPLE_W-1:0]   in_sample_y,
  input  logic signed [adi_pkg::SAMPLE_W-1:0]   in_sample_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [adi_pkg::DIST_W-1:0]     out_dist_x,
  output logic signed [adi_pkg::DIST_W-1:0]     out_dist_y,
  output logic signed [adi_pkg::DIST_W-1:0]     out_dist_z,
  output logic signed [adi_pkg::VEL_W-1:0]      out_vel_x,
  output logic signed [adi_pkg::VEL_W-1:0]      out_vel_y,
  output logic signed [adi_pkg::VEL_W-1:0]      out_vel_z,
  input  logic                                  cfg_we,
  input  logic        [adi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic        [adi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [adi_pkg::OFFSET_W-1:0] offset_r [adi_pkg::AXIS_PORTS];
  logic        [adi_pkg::SCALE_W-1:0]  scale_r;
  logic        [adi_pkg::STEP_W-1:0]   step_r;
  logic        [adi_pkg::BLEND_W-1:0]  blend_r;
  logic        [adi_pkg::FLOOR_W-1:0]  floor_r;
  logic        [adi_pkg::BLEND_W-1:0]  blend_wr;

  logic signed [adi_pkg::SAMPLE_W-1:0] sample_w [adi_pkg::AXIS_PORTS];
  logic signed [adi_pkg::DIST_W-1:0]   dist_w   [adi_pkg::AXIS_PORTS];
  logic signed [adi_pkg::VEL_W-1:0]    vel_w    [adi_pkg::AXIS_PORTS];

  adi_pkg::lane_ctl_t                  ctl;

  // Blend weights above one are held at one.
  assign blend_wr = (cfg_wdata[adi_pkg::BLEND_W-1:0] > adi_pkg::BLEND_ONE) ?
                    adi_pkg::BLEND_ONE : cfg_wdata[adi_pkg::BLEND_W-1:0];

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0] <= '0;
      offset_r[1] <= '0;
      offset_r[2] <= '0;
      scale_r     <= adi_pkg::SCALE_RST;
      step_r      <= adi_pkg::STEP_RST;
      blend_r     <= adi_pkg::BLEND_RST;
      floor_r     <= adi_pkg::FLOOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        adi_pkg::CFG_OFFSET_X:     offset_r[0] <= cfg_wdata[adi_pkg::OFFSET_W-1:0];
        adi_pkg::CFG_OFFSET_Y:     offset_r[1] <= cfg_wdata[adi_pkg::OFFSET_W-1:0];
        adi_pkg::CFG_OFFSET_Z:     offset_r[2] <= cfg_wdata[adi_pkg::OFFSET_W-1:0];
        adi_pkg::CFG_COUNT_SCALE:  scale_r     <= cfg_wdata[adi_pkg::SCALE_W-1:0];
        adi_pkg::CFG_STEP_TIME:    step_r      <= cfg_wdata[adi_pkg::STEP_W-1:0];
        adi_pkg::CFG_BLEND_WEIGHT: blend_r     <= blend_wr;
        adi_pkg::CFG_SPEED_FLOOR:  floor_r     <= cfg_wdata[adi_pkg::FLOOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  adi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  assign sample_w[0] = in_sample_x;
  assign sample_w[1] = in_sample_y;
  assign sample_w[2] = in_sample_z;

  // One lane per computed axis; the rest read as zero.
  for (genvar i = 0; i < adi_pkg::AXIS_PORTS; i++) begin : g_axis
    if (i < adi_pkg::AXES) begin : g_lane
      adi_lane u_lane (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sample       (sample_w[i]),
        .offset       (offset_r[i]),
        .count_scale  (scale_r),
        .step_time    (step_r),
        .blend_weight (blend_r),
        .speed_floor  (floor_r),
        .distance     (dist_w[i]),
        .vel          (vel_w[i])
      );
    end else begin : g_none
      assign dist_w[i] = '0;
      assign vel_w[i]  = '0;
    end
  end

  assign out_dist_x = dist_w[0];
  assign out_dist_y = dist_w[1];
  assign out_dist_z = dist_w[2];
  assign out_vel_x  = vel_w[0];
  assign out_vel_y  = vel_w[1];
  assign out_vel_z  = vel_w[2];

endmodule

>>> rtl/adi_checker.sv
// ----------------------------------------------------------------------------
// adi_props
// Port-level checks of the accelerometer double integrator, attached to the
// top level by a bind statement.
// ----------------------------------------------------------------------------
module adi_props (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [adi_pkg::DIST_W-1:0]     out_dist_x,
  input logic signed [adi_pkg::DIST_W-1:0]     out_dist_y,
  input logic signed [adi_pkg::DIST_W-1:0]     out_dist_z,
  input logic signed [adi_pkg::VEL_W-1:0]      out_vel_x,
  input logic signed [adi_pkg::VEL_W-1:0]      out_vel_y,
  input logic signed [adi_pkg::VEL_W-1:0]      out_vel_z
);

  // A taken sample keeps the input closed while the lanes work on it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a request was accepted");

  // A result only appears at the end of a computation.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid)) |-> $past(in_stall))
    else $error("result appeared without a sample being processed");

  // The input reopens only together with a fresh result.
  a_reopen_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(in_stall)) |-> out_valid)
    else $error("input reopened without a result being presented");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_dist_x) &&
      $stable(out_dist_y) && $stable(out_dist_z) && $stable(out_vel_x) &&
      $stable(out_vel_y) && $stable(out_vel_z)))
    else $error("stalled result changed or dropped");

endmodule

bind accel_double_integrator_top adi_props u_adi_props (.*);
